>>> rtl/cbmm_pkg.sv
// ----------------------------------------------------------------------------
// cbmm_pkg
// Shared types and constants for the coprocessor bus memory mapper.
// ----------------------------------------------------------------------------
package cbmm_pkg;

  // Storage sizes
  localparam int IRAM_BYTES          = 2048;
  localparam int IRAM_AW             = $clog2(IRAM_BYTES);
  localparam int BWRAM_BYTES_DEFAULT = 262144;
  localparam int ROM_BYTES           = 4194304;
  localparam logic [23:0] ROM_MASK   = 24'(ROM_BYTES - 1);

  // Address decode masks and match values
  localparam logic [23:0] MMIO_MASK   = 24'h40fe00;
  localparam logic [23:0] MMIO_MATCH  = 24'h002200;
  localparam logic [23:0] LOROM_MASK  = 24'h408000;
  localparam logic [23:0] LOROM_MATCH = 24'h008000;
  localparam logic [23:0] HIROM_MASK  = 24'hc00000;
  localparam logic [23:0] WIN_MASK    = 24'h40e000;
  localparam logic [23:0] WIN_MATCH   = 24'h006000;
  localparam logic [23:0] IRAM_MASK   = 24'h40f800;
  localparam logic [23:0] IRAM_MIRROR = 24'h003000;
  localparam logic [23:0] BANK_MASK   = 24'hf00000;
  localparam logic [23:0] BWRAM_BANK  = 24'h400000;
  localparam logic [23:0] BITMAP_BANK = 24'h600000;
  localparam logic [23:0] SLOW_MASK   = 24'hd00000;
  localparam logic [23:0] VEC_PAGE_MASK  = 24'hffffe0;
  localparam logic [23:0] VEC_PAGE_MATCH = 24'h007fe0;
  localparam logic [23:0] VEC_NMI_LO  = 24'h007fea;
  localparam logic [23:0] VEC_NMI_HI  = 24'h007feb;
  localparam logic [23:0] VEC_IRQ_LO  = 24'h007fee;
  localparam logic [23:0] VEC_IRQ_HI  = 24'h007fef;

  // Configuration register indexes
  localparam logic [2:0] CFG_ROM_BANK_MAP  = 3'd0;
  localparam logic [2:0] CFG_BWRAM_WINDOW  = 3'd1;
  localparam logic [2:0] CFG_BITMAP_FORMAT = 3'd2;
  localparam logic [2:0] CFG_NMI_VECTOR    = 3'd3;
  localparam logic [2:0] CFG_IRQ_VECTOR    = 3'd4;
  localparam logic [2:0] CFG_VEC_ENABLES   = 3'd5;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_PORT  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    TGT_IRAM     = 3'd0,
    TGT_BWRAM    = 3'd1,
    TGT_BITMAP   = 3'd2,
    TGT_ROM      = 3'd3,
    TGT_MMIO     = 3'd4,
    TGT_UNMAPPED = 3'd5,
    TGT_VECTOR   = 3'd6
  } target_t;

  typedef enum logic [2:0] {
    RD_ZERO  = 3'd0,
    RD_IRAM  = 3'd1,
    RD_BW    = 3'd2,
    RD_PIXEL = 3'd3,
    RD_CONST = 3'd4
  } rd_sel_t;

  // Decoded access, carried from the address stage to the data stage
  typedef struct packed {
    target_t     target;
    rd_sel_t     rd_sel;
    logic [7:0]  data;      // write byte, open-bus byte or vector byte
    logic        wr_iram;
    logic        wr_bw;
    logic        bmp_wr;    // merge a pixel into the stored byte
    logic        fmt;       // 1: 2bpp, 0: 4bpp
    logic [1:0]  pix;
    logic [23:0] fwd;
    logic        slow;
  } req_t;

endpackage

>>> rtl/cbmm_ram.sv
// ----------------------------------------------------------------------------
// cbmm_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cbmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/coprocessor_bus_memory_mapper.sv
// ----------------------------------------------------------------------------
// coprocessor_bus_memory_mapper
// Decodes one bus access per item, serves internal and battery RAM (plain and
// packed bitmap views), and forwards ROM and MMIO accesses.
// ----------------------------------------------------------------------------
//  channel  | signals                                       | handshake
//  ---------+-----------------------------------------------+-----------------
//  request  | kind, address, write_data                     | start && !busy
//  result   | target, read_data, forward_address, slow_access| done, one cycle
//  config   | cfg_index, cfg_data                           | cfg_valid && cfg_ready
//
//  One item per cycle while busy is low; its result shows with done in the cycle after it is accepted.
//  The address is decoded and both RAMs are read at the accept edge; the data
//  stage picks the byte and writes back (bitmap writes merge a pixel).
//  A write back and the next item's read of the same entry meet at one edge;
//  the written byte is forwarded to that next item.
//  After reset busy stays high while both RAMs clear.
//  The receiver cannot stall; done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module coprocessor_bus_memory_mapper
  import cbmm_pkg::*;
#(
  parameter int BWRAM_BYTES = BWRAM_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [23:0] address,
  input  logic [7:0]  write_data,
  output logic        done,
  output logic [2:0]  target,
  output logic [7:0]  read_data,
  output logic [23:0] forward_address,
  output logic        slow_access,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int BW_AW = $clog2(BWRAM_BYTES);

  // Configuration
  logic [15:0] rom_bank_map;
  logic [7:0]  bwram_window;
  logic        bitmap_format;
  logic [15:0] nmi_vector;
  logic [15:0] irq_vector;
  logic [1:0]  vec_enables;

  // Clear pass
  logic             clearing;
  logic [BW_AW-1:0] clr_addr;

  // Data stage
  logic               v1;
  req_t               req;
  req_t               dec;
  logic [BW_AW-1:0]   req_bw_addr;
  logic [IRAM_AW-1:0] req_iram_addr;
  logic [BW_AW-1:0]   dec_bw_addr;
  logic [IRAM_AW-1:0] dec_iram_addr;
  logic               accept;

  // RAM ports
  logic               iram_we, bw_we;
  logic [IRAM_AW-1:0] iram_waddr;
  logic [BW_AW-1:0]   bw_waddr;
  logic [7:0]         iram_wdata, bw_wdata, iram_q, bw_q;
  logic               iram_hit, bw_hit;
  logic [7:0]         iram_hit_data, bw_hit_data;
  logic [7:0]         iram_cur, bw_cur;

  // Decode terms
  logic is_mmio, is_lorom, is_hirom, is_win, is_iram, is_bwb, is_bmpb, slow;
  logic [23:0] lo_t, rom_t, rom_phys;
  logic [21:0] rom_a;
  logic [3:0]  rom_nib;
  logic        rom_lo, vec_hit;
  logic [7:0]  vec_byte;
  logic [19:0] win_plain, bmp_a, bmp_idx;
  logic [1:0]  bmp_pix;

  // Pixel merge
  logic [2:0] pix_sh;
  logic [7:0] pix_mask, pixel, merged;

  assign accept    = start && !busy;
  assign busy      = clearing;
  assign cfg_ready = 1'b1;

  assign is_mmio  = (address & MMIO_MASK) == MMIO_MATCH;
  assign is_lorom = (address & LOROM_MASK) == LOROM_MATCH;
  assign is_hirom = (address & HIROM_MASK) == HIROM_MASK;
  assign is_win   = (address & WIN_MASK) == WIN_MATCH;
  assign is_iram  = ((address & IRAM_MASK) == 24'h000000) ||
                    ((address & IRAM_MASK) == IRAM_MIRROR);
  assign is_bwb   = (address & BANK_MASK) == BWRAM_BANK;
  assign is_bmpb  = (address & BANK_MASK) == BITMAP_BANK;
  assign slow     = is_win || ((address & SLOW_MASK) == BWRAM_BANK);

  // ROM translation: fold the low-ROM banks, then apply the quarter bank map
  assign lo_t     = {2'b00, address[23], address[21:16], address[14:0]};
  assign rom_t    = is_lorom ? lo_t : address;
  assign rom_lo   = (rom_t[23:22] == 2'b00);
  assign rom_a    = rom_t[21:0];
  assign rom_nib  = rom_bank_map[{rom_a[21:20], 2'b00} +: 4];
  assign rom_phys = ((rom_lo && !rom_nib[3]) ? {2'b00, rom_a}
                                             : {1'b0, rom_nib[2:0], rom_a[19:0]})
                    & ROM_MASK;

  always_comb begin
    vec_hit  = 1'b0;
    vec_byte = 8'h00;
    if ((rom_t & VEC_PAGE_MASK) == VEC_PAGE_MATCH) begin
      if (rom_t == VEC_NMI_LO && vec_enables[0]) begin
        vec_hit = 1'b1; vec_byte = nmi_vector[7:0];
      end else if (rom_t == VEC_NMI_HI && vec_enables[0]) begin
        vec_hit = 1'b1; vec_byte = nmi_vector[15:8];
      end else if (rom_t == VEC_IRQ_LO && vec_enables[1]) begin
        vec_hit = 1'b1; vec_byte = irq_vector[7:0];
      end else if (rom_t == VEC_IRQ_HI && vec_enables[1]) begin
        vec_hit = 1'b1; vec_byte = irq_vector[15:8];
      end
    end
  end

  // Window and bitmap addressing
  assign win_plain = {2'b00, bwram_window[4:0], address[12:0]};
  assign bmp_a     = is_win ? {bwram_window[6:0], address[12:0]} : address[19:0];
  assign bmp_idx   = bitmap_format ? {2'b00, bmp_a[19:2]} : {1'b0, bmp_a[19:1]};
  assign bmp_pix   = bitmap_format ? bmp_a[1:0] : {1'b0, bmp_a[0]};
  assign dec_iram_addr = address[IRAM_AW-1:0];

  always_comb begin
    dec         = '0;
    dec.target  = TGT_UNMAPPED;
    dec.rd_sel  = RD_ZERO;
    dec.fmt     = bitmap_format;
    dec.pix     = bmp_pix;
    dec_bw_addr = address[BW_AW-1:0];
    case (kind_t'(kind))
      KIND_READ: begin
        dec.slow = slow;
        if (is_mmio) begin
          dec.target = TGT_MMIO;
          dec.fwd    = address;
        end else if (is_lorom || is_hirom) begin
          if (vec_hit) begin
            dec.target = TGT_VECTOR;
            dec.rd_sel = RD_CONST;
            dec.data   = vec_byte;
          end else begin
            dec.target = TGT_ROM;
            dec.fwd    = rom_phys;
          end
        end else if (is_win) begin
          if (!bwram_window[7]) begin
            dec.target  = TGT_BWRAM;
            dec.rd_sel  = RD_BW;
            dec_bw_addr = win_plain[BW_AW-1:0];
          end else begin
            dec.target  = TGT_BITMAP;
            dec.rd_sel  = RD_PIXEL;
            dec_bw_addr = bmp_idx[BW_AW-1:0];
          end
        end else if (is_iram) begin
          dec.target = TGT_IRAM;
          dec.rd_sel = RD_IRAM;
        end else if (is_bwb) begin
          dec.target = TGT_BWRAM;
          dec.rd_sel = RD_BW;
        end else if (is_bmpb) begin
          dec.target  = TGT_BITMAP;
          dec.rd_sel  = RD_PIXEL;
          dec_bw_addr = bmp_idx[BW_AW-1:0];
        end else begin
          dec.rd_sel = RD_CONST;
          dec.data   = write_data;
        end
      end
      KIND_WRITE: begin
        dec.slow = slow;
        dec.data = write_data;
        if (is_mmio) begin
          dec.target = TGT_MMIO;
          dec.fwd    = address;
        end else if (is_win) begin
          dec.wr_bw = 1'b1;
          if (!bwram_window[7]) begin
            dec.target  = TGT_BWRAM;
            dec_bw_addr = win_plain[BW_AW-1:0];
          end else begin
            dec.target  = TGT_BITMAP;
            dec.bmp_wr  = 1'b1;
            dec_bw_addr = bmp_idx[BW_AW-1:0];
          end
        end else if (is_iram) begin
          dec.target  = TGT_IRAM;
          dec.wr_iram = 1'b1;
        end else if (is_bwb) begin
          dec.target = TGT_BWRAM;
          dec.wr_bw  = 1'b1;
        end else if (is_bmpb) begin
          dec.target  = TGT_BITMAP;
          dec.wr_bw   = 1'b1;
          dec.bmp_wr  = 1'b1;
          dec_bw_addr = bmp_idx[BW_AW-1:0];
        end
      end
      KIND_PORT: begin
        if (is_lorom || is_hirom) begin
          if (vec_hit) begin
            dec.target = TGT_VECTOR;
            dec.rd_sel = RD_CONST;
            dec.data   = vec_byte;
          end else begin
            dec.target = TGT_ROM;
            dec.fwd    = rom_phys;
          end
        end else if (is_win || is_bwb) begin
          // the port sees the window as plain battery RAM
          dec.target = TGT_BWRAM;
          dec.rd_sel = RD_BW;
        end else if (is_iram) begin
          dec.target = TGT_IRAM;
          dec.rd_sel = RD_IRAM;
        end
      end
      default: begin
        dec.target = TGT_UNMAPPED;
      end
    endcase
  end

  // Data stage: pick forwarded bytes, extract or merge the pixel
  assign iram_cur = iram_hit ? iram_hit_data : iram_q;
  assign bw_cur   = bw_hit ? bw_hit_data : bw_q;
  assign pix_sh   = req.fmt ? {req.pix, 1'b0} : {req.pix[0], 2'b00};
  assign pix_mask = req.fmt ? 8'h03 : 8'h0f;
  assign pixel    = (bw_cur >> pix_sh) & pix_mask;
  assign merged   = (bw_cur & ~(pix_mask << pix_sh)) | ((req.data & pix_mask) << pix_sh);

  always_comb begin
    case (req.rd_sel)
      RD_ZERO:  read_data = 8'h00;
      RD_IRAM:  read_data = iram_cur;
      RD_BW:    read_data = bw_cur;
      RD_PIXEL: read_data = pixel;
      RD_CONST: read_data = req.data;
      default:  read_data = 8'h00;
    endcase
  end

  assign done            = v1;
  assign target          = req.target;
  assign forward_address = req.fwd;
  assign slow_access     = req.slow;

  // Write ports: clear pass, or write back from the data stage
  assign iram_we    = clearing || (v1 && req.wr_iram);
  assign iram_waddr = clearing ? clr_addr[IRAM_AW-1:0] : req_iram_addr;
  assign iram_wdata = clearing ? 8'h00 : req.data;
  assign bw_we      = clearing || (v1 && req.wr_bw);
  assign bw_waddr   = clearing ? clr_addr : req_bw_addr;
  assign bw_wdata   = clearing ? 8'h00 : (req.bmp_wr ? merged : req.data);

  cbmm_ram #(.WIDTH(8), .DEPTH(IRAM_BYTES)) u_iram (
    .clk   (clk),
    .we    (iram_we),
    .waddr (iram_waddr),
    .wdata (iram_wdata),
    .raddr (dec_iram_addr),
    .rdata (iram_q)
  );

  cbmm_ram #(.WIDTH(8), .DEPTH(BWRAM_BYTES)) u_bwram (
    .clk   (clk),
    .we    (bw_we),
    .waddr (bw_waddr),
    .wdata (bw_wdata),
    .raddr (dec_bw_addr),
    .rdata (bw_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clr_addr      <= '0;
      v1            <= 1'b0;
      rom_bank_map  <= '0;
      bwram_window  <= '0;
      bitmap_format <= 1'b0;
      nmi_vector    <= '0;
      irq_vector    <= '0;
      vec_enables   <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (&clr_addr) begin
          clearing <= 1'b0;
        end
      end
      v1 <= accept;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROM_BANK_MAP:  rom_bank_map  <= cfg_data;
          CFG_BWRAM_WINDOW:  bwram_window  <= cfg_data[7:0];
          CFG_BITMAP_FORMAT: bitmap_format <= cfg_data[0];
          CFG_NMI_VECTOR:    nmi_vector    <= cfg_data;
          CFG_IRQ_VECTOR:    irq_vector    <= cfg_data;
          CFG_VEC_ENABLES:   vec_enables   <= cfg_data[1:0];
          default: begin
            // unknown index: drop the write
          end
        endcase
      end
    end
  end

  // Payload: capture the decoded item and the bytes written at the read edge
  always_ff @(posedge clk) begin
    if (accept) begin
      req           <= dec;
      req_bw_addr   <= dec_bw_addr;
      req_iram_addr <= dec_iram_addr;
    end
    iram_hit      <= iram_we && (iram_waddr == dec_iram_addr);
    iram_hit_data <= iram_wdata;
    bw_hit        <= bw_we && (bw_waddr == dec_bw_addr);
    bw_hit_data   <= bw_wdata;
  end

  // Checks
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without an accepted item");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !done)
    else $error("result during clear pass");

  a_port_never_slow: assert property (@(posedge clk) disable iff (rst)
    done && ($past(kind) == KIND_PORT) |-> !slow_access)
    else $error("port read flagged slow");

  a_fwd_only_forwarded: assert property (@(posedge clk) disable iff (rst)
    done && (target != TGT_ROM) && (target != TGT_MMIO) |-> forward_address == 24'h000000)
    else $error("forward address on an internal access");

  a_clear_runs_full: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(&clr_addr))
    else $error("clear pass ended early");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bus memory mapper: drives reads, writes and
// port reads over every address region and a range of register settings, predicts each
// result with a software copy of both RAMs, and checks every field.
// ----------------------------------------------------------------------------
module tb_top;
  import cbmm_pkg::*;

  localparam logic [1:0] KIND_NONE     = 2'd3;
  localparam logic [2:0] CFG_UNUSED_A  = 3'd6;
  localparam logic [2:0] CFG_UNUSED_B  = 3'd7;
  localparam int         BW_AW         = $clog2(BWRAM_BYTES_DEFAULT);
  localparam int         WATCHDOG_MAX  = 800000;
  localparam int         PHASES        = 6;
  localparam int         PHASE_ITEMS   = 90;

  typedef struct packed {
    logic [2:0]  tgt;
    logic [7:0]  data;
    logic [23:0] fwd;
    logic        slow;
  } access_result_t;

  typedef enum int {
    ZONE_MMIO, ZONE_LOROM, ZONE_HIROM, ZONE_WINDOW, ZONE_IRAM,
    ZONE_BWRAM, ZONE_BITMAP, ZONE_GAP, ZONE_NOISE
  } addr_zone_t;

  class access_tracker;
    bit [7:0]       iram_mem [IRAM_BYTES];
    bit [7:0]       bw_mem [BWRAM_BYTES_DEFAULT];
    bit [15:0]      bank_map;
    bit [7:0]       win_reg;
    bit             fmt_2bpp;
    bit [15:0]      nmi_vec;
    bit [15:0]      irq_vec;
    bit [1:0]       vec_en;
    access_result_t results_due[$];
    int             failures;

    function void write_register(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_ROM_BANK_MAP:  bank_map = val;
        CFG_BWRAM_WINDOW:  win_reg = val[7:0];
        CFG_BITMAP_FORMAT: fmt_2bpp = val[0];
        CFG_NMI_VECTOR:    nmi_vec = val;
        CFG_IRQ_VECTOR:    irq_vec = val;
        CFG_VEC_ENABLES:   vec_en = val[1:0];
        default: ;
      endcase
    endfunction

    function logic [BW_AW-1:0] bw_index(logic [23:0] x);
      return x[BW_AW-1:0];
    endfunction

    function logic [7:0] pixel_read(logic [19:0] p);
      logic [7:0] v;
      if (!fmt_2bpp) begin
        v = bw_mem[bw_index({5'd0, p[19:1]})];
        return p[0] ? {4'h0, v[7:4]} : {4'h0, v[3:0]};
      end
      v = bw_mem[bw_index({6'd0, p[19:2]})];
      return {6'h0, v[{p[1:0], 1'b0} +: 2]};
    endfunction

    function void pixel_write(logic [19:0] p, logic [7:0] d);
      logic [7:0] v;
      if (!fmt_2bpp) begin
        v = bw_mem[bw_index({5'd0, p[19:1]})];
        if (p[0]) v[7:4] = d[3:0];
        else v[3:0] = d[3:0];
        bw_mem[bw_index({5'd0, p[19:1]})] = v;
      end else begin
        v = bw_mem[bw_index({6'd0, p[19:2]})];
        v[{p[1:0], 1'b0} +: 2] = d[1:0];
        bw_mem[bw_index({6'd0, p[19:2]})] = v;
      end
    endfunction

    // ROM lookup on a folded low-ROM or raw high-ROM address, vector overrides first
    function access_result_t rom_lookup(logic [23:0] t);
      access_result_t r;
      logic [3:0]  nib;
      logic [23:0] phys;
      r = '{tgt: TGT_ROM, data: 8'h00, fwd: 24'h0, slow: 1'b0};
      r.tgt = TGT_VECTOR;
      if (t == VEC_NMI_LO && vec_en[0]) begin r.data = nmi_vec[7:0]; return r; end
      if (t == VEC_NMI_HI && vec_en[0]) begin r.data = nmi_vec[15:8]; return r; end
      if (t == VEC_IRQ_LO && vec_en[1]) begin r.data = irq_vec[7:0]; return r; end
      if (t == VEC_IRQ_HI && vec_en[1]) begin r.data = irq_vec[15:8]; return r; end
      r.tgt = TGT_ROM;
      nib = bank_map[{t[21:20], 2'b00} +: 4];
      if (t < 24'h400000 && !nib[3]) phys = {2'b00, t[21:0]};
      else phys = {1'b0, nib[2:0], t[19:0]};
      r.fwd = phys & ROM_MASK;
      return r;
    endfunction

    function access_result_t map_access(logic [1:0] k, logic [23:0] a, logic [7:0] d);
      access_result_t r;
      logic [19:0]    w;
      logic [23:0]    folded;
      logic           in_iram;
      logic           in_window;
      r = '{tgt: TGT_UNMAPPED, data: 8'h00, fwd: 24'h0, slow: 1'b0};
      w = win_reg[7] ? {win_reg[6:0], a[12:0]} : {2'b00, win_reg[4:0], a[12:0]};
      folded = {2'b00, a[23], a[21:16], a[14:0]};
      in_iram = (a & IRAM_MASK) == 24'h0 || (a & IRAM_MASK) == IRAM_MIRROR;
      in_window = (a & WIN_MASK) == WIN_MATCH;
      case (k)
        KIND_READ: begin
          if ((a & MMIO_MASK) == MMIO_MATCH) begin
            r.tgt = TGT_MMIO;
            r.fwd = a;
          end else if ((a & LOROM_MASK) == LOROM_MATCH) begin
            r = rom_lookup(folded);
          end else if ((a & HIROM_MASK) == HIROM_MASK) begin
            r = rom_lookup(a);
          end else if (in_window) begin
            if (!win_reg[7]) begin
              r.tgt = TGT_BWRAM;
              r.data = bw_mem[bw_index({4'h0, w})];
            end else begin
              r.tgt = TGT_BITMAP;
              r.data = pixel_read(w);
            end
          end else if (in_iram) begin
            r.tgt = TGT_IRAM;
            r.data = iram_mem[a[IRAM_AW-1:0]];
          end else if ((a & BANK_MASK) == BWRAM_BANK) begin
            r.tgt = TGT_BWRAM;
            r.data = bw_mem[bw_index(a)];
          end else if ((a & BANK_MASK) == BITMAP_BANK) begin
            r.tgt = TGT_BITMAP;
            r.data = pixel_read(a[19:0]);
          end else begin
            r.data = d;
          end
        end
        KIND_WRITE: begin
          // ROM and unmapped writes drop silently
          if ((a & MMIO_MASK) == MMIO_MATCH) begin
            r.tgt = TGT_MMIO;
            r.fwd = a;
          end else if (in_window) begin
            if (!win_reg[7]) begin
              r.tgt = TGT_BWRAM;
              bw_mem[bw_index({4'h0, w})] = d;
            end else begin
              r.tgt = TGT_BITMAP;
              pixel_write(w, d);
            end
          end else if (in_iram) begin
            r.tgt = TGT_IRAM;
            iram_mem[a[IRAM_AW-1:0]] = d;
          end else if ((a & BANK_MASK) == BWRAM_BANK) begin
            r.tgt = TGT_BWRAM;
            bw_mem[bw_index(a)] = d;
          end else if ((a & BANK_MASK) == BITMAP_BANK) begin
            r.tgt = TGT_BITMAP;
            pixel_write(a[19:0], d);
          end
        end
        KIND_PORT: begin
          // port never sees MMIO and reads the window as plain battery RAM
          if ((a & LOROM_MASK) == LOROM_MATCH) begin
            r = rom_lookup(folded);
          end else if ((a & HIROM_MASK) == HIROM_MASK) begin
            r = rom_lookup(a);
          end else if (in_window || (a & BANK_MASK) == BWRAM_BANK) begin
            r.tgt = TGT_BWRAM;
            r.data = bw_mem[bw_index(a)];
          end else if (in_iram) begin
            r.tgt = TGT_IRAM;
            r.data = iram_mem[a[IRAM_AW-1:0]];
          end
        end
        default: ;
      endcase
      r.slow = (k == KIND_READ || k == KIND_WRITE) &&
               (in_window || (a & SLOW_MASK) == BWRAM_BANK);
      return r;
    endfunction

    function void note_access(logic [1:0] k, logic [23:0] a, logic [7:0] d);
      results_due.push_back(map_access(k, a, d));
    endfunction

    function void check_result(logic [2:0] tgt, logic [7:0] rd, logic [23:0] fa,
                               logic sl);
      access_result_t exp;
      if (results_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result with no access pending: tgt=%0d data=%h fwd=%h slow=%b",
                   $realtime, tgt, rd, fa, sl);
        return;
      end
      exp = results_due.pop_front();
      if (tgt !== exp.tgt || rd !== exp.data || fa !== exp.fwd || sl !== exp.slow) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch exp tgt=%0d data=%h fwd=%h slow=%b, got tgt=%0d data=%h fwd=%h slow=%b",
                   $realtime, exp.tgt, exp.data, exp.fwd, exp.slow, tgt, rd, fa, sl);
      end
    endfunction

    function void close_out();
      if (results_due.size() != 0) begin
        $display("%0d accesses never produced a result", results_due.size());
        failures += results_due.size();
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  kind = KIND_READ;
  logic [23:0] address = 24'h0;
  logic [7:0]  write_data = 8'h0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = CFG_ROM_BANK_MAP;
  logic [15:0] cfg_data = 16'h0;
  logic        busy;
  logic        done;
  logic [2:0]  target;
  logic [7:0]  read_data;
  logic [23:0] forward_address;
  logic        slow_access;
  logic        cfg_ready;

  access_tracker sb = new;
  bit            gaps_on = 1'b1;
  int            stall_cycles = 0;

  coprocessor_bus_memory_mapper u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .address(address), .write_data(write_data),
    .done(done), .target(target), .read_data(read_data),
    .forward_address(forward_address), .slow_access(slow_access),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (!rst && done)
      sb.check_result(target, read_data, forward_address, slow_access);
  end

  // Count cycles with no handshake of any kind; the clearing pass is the longest
  always @(negedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_MAX) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Leave start high on return so back-to-back items need no second assignment
  task automatic send_item(input logic [1:0] k, input logic [23:0] a,
                           input logic [7:0] d);
    while (gaps_on && $urandom_range(99) < 25) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    address <= a;
    write_data <= d;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_access(k, a, d);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    sb.write_register(idx, val);
  endtask

  task automatic apply_settings(input logic [15:0] map, input logic [7:0] win,
                                input logic fmt, input logic [15:0] nmi,
                                input logic [15:0] irq, input logic [1:0] en);
    start <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    write_reg(CFG_ROM_BANK_MAP, map);
    write_reg(CFG_BWRAM_WINDOW, {8'($urandom), win});
    write_reg($urandom_range(1) ? CFG_UNUSED_A : CFG_UNUSED_B, 16'($urandom));
    write_reg(CFG_BITMAP_FORMAT, {15'($urandom), fmt});
    write_reg(CFG_NMI_VECTOR, nmi);
    write_reg(CFG_IRQ_VECTOR, irq);
    write_reg(CFG_VEC_ENABLES, {14'($urandom), en});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [1:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 40) return KIND_READ;
    if (r < 70) return KIND_WRITE;
    if (r < 96) return KIND_PORT;
    return KIND_NONE;
  endfunction

  // Narrow picks reuse a few entries so reads see earlier writes
  function automatic logic [23:0] pick_address();
    logic [7:0] bank;
    logic       narrow;
    bank = 8'($urandom);
    bank[6] = 1'b0;
    narrow = $urandom_range(1) == 0;
    case (addr_zone_t'($urandom_range(ZONE_NOISE)))
      ZONE_MMIO:   return {bank, 16'h2200 | 16'($urandom_range(16'h1ff))};
      ZONE_LOROM:  return narrow ? {8'h00, 11'h7ff, 5'($urandom)}
                                 : {bank, 1'b1, 15'($urandom)};
      ZONE_HIROM:  return {2'b11, 22'($urandom)};
      ZONE_WINDOW: return {bank, 3'b011,
                           narrow ? 13'($urandom_range(63)) : 13'($urandom)};
      ZONE_IRAM:   return {bank, $urandom_range(1) ? 5'b00110 : 5'b00000,
                           narrow ? 11'($urandom_range(63)) : 11'($urandom)};
      ZONE_BWRAM:  return {4'h4, narrow ? 20'($urandom_range(63)) : 20'($urandom)};
      ZONE_BITMAP: return {4'h6, narrow ? 20'($urandom_range(255)) : 20'($urandom)};
      ZONE_GAP:    return narrow ? {$urandom_range(1) ? 4'h5 : 4'h7, 20'($urandom)}
                                 : {bank, 16'h0800 + 16'($urandom_range(16'h17ff))};
      default:     return 24'($urandom);
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: plain window on block 0, 4bpp, no overrides
    send_item(KIND_READ,  24'h000000, 8'h00);
    send_item(KIND_WRITE, 24'h000000, 8'hff);
    send_item(KIND_READ,  24'h003000, 8'h00);
    send_item(KIND_WRITE, 24'h8037ff, 8'h5a);
    send_item(KIND_PORT,  24'h0007ff, 8'h00);
    send_item(KIND_READ,  24'h002200, 8'h00);
    send_item(KIND_WRITE, 24'hbf23ff, 8'ha5);
    send_item(KIND_PORT,  24'h002200, 8'hff);
    send_item(KIND_READ,  24'h008000, 8'h00);
    send_item(KIND_READ,  24'hffffff, 8'h00);
    send_item(KIND_READ,  24'h00ffea, 8'h00);
    send_item(KIND_WRITE, 24'h00ffff, 8'h11);
    send_item(KIND_WRITE, 24'h006000, 8'h3c);
    send_item(KIND_READ,  24'h806000, 8'h00);
    send_item(KIND_WRITE, 24'h400000, 8'ha5);
    send_item(KIND_PORT,  24'h4fffff, 8'h00);
    send_item(KIND_WRITE, 24'h600001, 8'hf7);
    send_item(KIND_READ,  24'h600001, 8'h00);
    send_item(KIND_READ,  24'h500000, 8'h77);
    send_item(KIND_NONE,  24'h400000, 8'hff);

    // Bitmap window, 2bpp, both overrides on, banked upper quarters
    apply_settings(16'hf9a5, 8'h80, 1'b1, 16'hbeef, 16'h1234, 2'b11);
    send_item(KIND_READ,  24'h00ffea, 8'h00);
    send_item(KIND_READ,  24'h00ffeb, 8'h00);
    send_item(KIND_PORT,  24'h00ffee, 8'h00);
    send_item(KIND_READ,  24'h00ffef, 8'h00);
    send_item(KIND_WRITE, 24'h006003, 8'hff);
    send_item(KIND_PORT,  24'h006000, 8'h00);
    send_item(KIND_READ,  24'hc00000, 8'h00);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)
        apply_settings(16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000, 2'b00);
      else if (ph == 1)
        apply_settings(16'hffff, 8'hff, 1'b1, 16'hffff, 16'hffff, 2'b11);
      else
        apply_settings(16'($urandom), 8'($urandom), 1'($urandom), 16'($urandom),
                       16'($urandom), 2'($urandom));
      gaps_on = ph != 2;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_item(pick_kind(), pick_address(), 8'($urandom));
    end

    start <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    sb.close_out();
    if (sb.failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/cbmm_pkg.sv
rtl/cbmm_ram.sv
rtl/coprocessor_bus_memory_mapper.sv
sim/tb_top.sv
